[hdl/source_line_token_scanner_top_defines.svh]
// Assertion macros shared by the token scanner modules.
`ifndef SOURCE_LINE_TOKEN_SCANNER_TOP_DEFINES_SVH
`define SOURCE_LINE_TOKEN_SCANNER_TOP_DEFINES_SVH

// A property that holds at every clock edge outside reset.
`define SLTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define SLTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SLTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/slts_pkg.sv]
// Types and constants shared by the source line token scanner.
package slts_pkg;

  localparam int unsigned MAX_LINE   = 4096;
  localparam int unsigned DEPTH_BITS = 12;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned LINE_W     = 13;
  localparam int unsigned MAX_RES    = 4;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned FIFO_DEPTH = 8;

  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_NUMBER  = 3'd1;
  localparam logic [2:0] MODE_IDENT   = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_BLOCK   = 3'd4;
  localparam logic [2:0] MODE_LINECMT = 3'd5;

  typedef enum logic [2:0] {
    KIND_NUMBER   = 3'd0,
    KIND_IDENT    = 3'd1,
    KIND_STRING   = 3'd2,
    KIND_COMMENT  = 3'd3,
    KIND_OPERATOR = 3'd4,
    KIND_OPEN     = 3'd5,
    KIND_CLOSE    = 3'd6,
    KIND_STATUS   = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       line_end;
  } in_t;

  typedef struct packed {
    kind_e                         kind;
    logic [POS_W-1:0]              span_start;
    logic [LINE_W-1:0]             span_length;
    logic signed [DEPTH_BITS-1:0]  brace_depth;
    logic                          in_block_comment;
    logic                          last;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    res_t [MAX_RES-1:0]  item;
  } res_batch_t;

  typedef struct packed {
    logic [2:0]                    mode;
    logic [POS_W-1:0]              token_begin;
    logic [7:0]                    quote_byte;
    logic [7:0]                    previous_byte;
    logic                          held_valid;
    logic [LINE_W-1:0]             line_position;
    logic signed [DEPTH_BITS-1:0]  depth_count;
  } scan_state_t;

endpackage

[hdl/slts_step.sv]
// Next-state and result logic for one scanned byte and line end.
module slts_step
  import slts_pkg::*;
(
  input  scan_state_t state_i,
  input  in_t         item_i,
  output scan_state_t state_o,
  output res_batch_t  batch_o
);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic res_batch_t add_res(res_batch_t b, kind_e k, logic [POS_W-1:0] st,
                                         logic [LINE_W-1:0] len,
                                         logic signed [DEPTH_BITS-1:0] d, logic blk);
    res_batch_t nb;
    nb = b;
    if (b.count < CNT_W'(MAX_RES)) begin
      nb.item[b.count[IDX_W-1:0]].kind             = k;
      nb.item[b.count[IDX_W-1:0]].span_start       = st;
      nb.item[b.count[IDX_W-1:0]].span_length      = len;
      nb.item[b.count[IDX_W-1:0]].brace_depth      = d;
      nb.item[b.count[IDX_W-1:0]].in_block_comment = blk;
      nb.item[b.count[IDX_W-1:0]].last             = 1'b0;
      nb.count = b.count + CNT_W'(1);
    end
    return nb;
  endfunction

  always_comb begin
    scan_state_t       s;
    res_batch_t        b;
    logic [7:0]        c;
    logic [POS_W-1:0]  pos;
    logic [LINE_W-1:0] len;
    logic              do_take;
    logic              do_start;
    logic              blk;

    s        = state_i;
    b        = '0;
    c        = item_i.ch;
    pos      = s.line_position[POS_W-1:0];
    len      = '0;
    do_take  = 1'b0;
    do_start = 1'b0;
    blk      = 1'b0;

    if (item_i.has_char && s.line_position < LINE_W'(MAX_LINE)) begin
      do_take = 1'b1;
      // A held byte is resolved by the byte that follows it.
      if (s.held_valid) begin
        s.held_valid = 1'b0;
        if (s.mode == MODE_BLOCK) begin
          if (c == CH_SLASH) begin
            b = add_res(b, KIND_COMMENT, s.token_begin,
                        {1'b0, pos} + LINE_W'(1) - {1'b0, s.token_begin}, s.depth_count, 1'b0);
            s.mode  = MODE_START;
            do_take = 1'b0;
          end
        end else if (c == CH_STAR) begin
          s.mode  = MODE_BLOCK;
          do_take = 1'b0;
        end else if (c == CH_SLASH) begin
          s.mode  = MODE_LINECMT;
          do_take = 1'b0;
        end else begin
          b = add_res(b, KIND_OPERATOR, s.token_begin, LINE_W'(1), s.depth_count, 1'b0);
        end
      end

      if (do_take) begin
        unique case (s.mode)
          MODE_NUMBER: begin
            if (!is_digit(c)) begin
              b = add_res(b, KIND_NUMBER, s.token_begin,
                          {1'b0, pos} - {1'b0, s.token_begin}, s.depth_count, 1'b0);
              s.mode   = MODE_START;
              do_start = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (!(is_digit(c) || is_letter(c) || c == CH_UNDER)) begin
              b = add_res(b, KIND_IDENT, s.token_begin,
                          {1'b0, pos} - {1'b0, s.token_begin}, s.depth_count, 1'b0);
              s.mode   = MODE_START;
              do_start = 1'b1;
            end
          end
          MODE_STRING: begin
            if (c == s.quote_byte && s.previous_byte != CH_BSLASH) begin
              b = add_res(b, KIND_STRING, s.token_begin,
                          {1'b0, pos} + LINE_W'(1) - {1'b0, s.token_begin}, s.depth_count, 1'b0);
              s.mode = MODE_START;
            end
          end
          MODE_BLOCK: begin
            if (c == CH_STAR) begin
              s.held_valid = 1'b1;
            end
          end
          MODE_LINECMT: begin
          end
          default: begin
            s.mode   = MODE_START;
            do_start = 1'b1;
          end
        endcase

        if (do_start) begin
          s.token_begin = pos;
          if (is_space(c)) begin
          end else if (is_digit(c)) begin
            s.mode = MODE_NUMBER;
          end else if (is_letter(c) || c == CH_UNDER) begin
            s.mode = MODE_IDENT;
          end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            s.mode       = MODE_STRING;
            s.quote_byte = c;
          end else if (c == CH_SLASH) begin
            s.held_valid = 1'b1;
          end else if (c == CH_LBRACE) begin
            if (s.depth_count != DEPTH_MAX) begin
              s.depth_count = s.depth_count + DEPTH_BITS'(1);
            end
            b = add_res(b, KIND_OPEN, pos, LINE_W'(1), s.depth_count, 1'b0);
          end else if (c == CH_RBRACE) begin
            if (s.depth_count != DEPTH_MIN) begin
              s.depth_count = s.depth_count - DEPTH_BITS'(1);
            end
            b = add_res(b, KIND_CLOSE, pos, LINE_W'(1), s.depth_count, 1'b0);
          end else if (c != CH_LPAREN && c != CH_RPAREN && c != CH_LBRACK && c != CH_RBRACK) begin
            b = add_res(b, KIND_OPERATOR, pos, LINE_W'(1), s.depth_count, 1'b0);
          end
        end
      end

      s.previous_byte = c;
      s.line_position = s.line_position + LINE_W'(1);
    end

    if (item_i.line_end) begin
      len = s.line_position;
      // A slash still held at line end stands alone as an operator.
      if (s.held_valid) begin
        s.held_valid = 1'b0;
        if (s.mode != MODE_BLOCK) begin
          b = add_res(b, KIND_OPERATOR, s.token_begin, LINE_W'(1), s.depth_count, 1'b0);
        end
      end
      case (s.mode)
        MODE_NUMBER: begin
          b = add_res(b, KIND_NUMBER, s.token_begin, len - {1'b0, s.token_begin},
                      s.depth_count, 1'b0);
        end
        MODE_IDENT: begin
          b = add_res(b, KIND_IDENT, s.token_begin, len - {1'b0, s.token_begin},
                      s.depth_count, 1'b0);
        end
        MODE_LINECMT, MODE_BLOCK: begin
          if (len > {1'b0, s.token_begin}) begin
            b = add_res(b, KIND_COMMENT, s.token_begin, len - {1'b0, s.token_begin},
                        s.depth_count, 1'b0);
          end
        end
        default: begin
        end
      endcase
      blk = (s.mode == MODE_BLOCK);
      b = add_res(b, KIND_STATUS, '0, len, s.depth_count, blk);
      s.mode = blk ? MODE_BLOCK : MODE_START;
      // A line that leaves the depth negative restarts the next line clean.
      if (s.depth_count[DEPTH_BITS-1]) begin
        s.depth_count = '0;
        s.mode        = MODE_START;
      end
      s.token_begin   = '0;
      s.quote_byte    = '0;
      s.previous_byte = '0;
      s.line_position = '0;
    end

    if (b.count != '0) begin
      b.item[b.count[IDX_W-1:0] - IDX_W'(1)].last = 1'b1;
    end

    state_o = s;
    batch_o = b;
  end

endmodule

[hdl/slts_res_fifo.sv]
// Result queue: takes up to four results per push and delivers one per pop.
`include "source_line_token_scanner_top_defines.svh"

module slts_res_fifo
  import slts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  res_batch_t batch_i,
  output logic       room_o,
  input  logic       pop_i,
  output logic       valid_o,
  output res_t       data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CW    = PTR_W + 1;

  res_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CNT_W-1:0] push_cnt;

  assign push_cnt = push_i ? batch_i.count : '0;
  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_cnt);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop_i);
  assign count_d  = count_q + CW'(push_cnt) - CW'(pop_i);

  // Room is judged on the registered fill so that a full batch always fits.
  assign room_o  = count_q <= CW'(FIFO_DEPTH - MAX_RES);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (CNT_W'(i) < batch_i.count) begin
          mem_q[wr_ptr_q + PTR_W'(i)] <= batch_i.item[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `SLTS_ASSERT(a_fill_bound, count_q <= CW'(FIFO_DEPTH), "result queue overfilled")
  `SLTS_ASSERT_IMPL(a_push_room, push_i, room_o, "batch written without room")
  `SLTS_ASSERT_NEXT(a_pop_drains, pop_i && !push_i, count_q == $past(count_q) - CW'(1), "pop did not drain")

endmodule

[hdl/source_line_token_scanner_top.sv]
// Top level of the source line token scanner.
//
//   Channel | Direction | Payload | Handshake
//   --------+-----------+---------+---------------------------------
//   in      | input     | in_t    | in_valid_i / in_stall_o
//   out     | output    | res_t   | out_valid_o / out_stall_i
//
// One input transaction is taken per cycle while the result queue has room for four results.
// Each item waits in the input register until the queue has room, and the scan logic turns
// it there into zero to four results, which the queue registers.
// The result queue delivers one result per cycle unless the output stalls, so its single read
// port sets the rate for items that produce several results, such as line ends.
// Reset is asynchronous and clears the scan state and the queue at once; no clearing pass.
// A stalled output holds the head result; the input stalls while the queue lacks room.
`include "source_line_token_scanner_top_defines.svh"

module source_line_token_scanner_top
  import slts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_data_o
);

  in_t         in_q;
  logic        in_valid_q;
  scan_state_t state_q, state_d;
  res_batch_t  batch;
  logic        room;
  logic        fire;
  logic        in_take;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  slts_step u_step (
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d),
    .batch_o (batch)
  );

  slts_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .batch_i (batch),
    .room_o  (room),
    .pop_i   (out_valid_o && !out_stall_i),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      state_q.mode          <= MODE_START;
      state_q.token_begin   <= '0;
      state_q.quote_byte    <= '0;
      state_q.previous_byte <= '0;
      state_q.held_valid    <= 1'b0;
      state_q.line_position <= '0;
      state_q.depth_count   <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  `SLTS_ASSERT_NEXT(a_item_held, in_valid_q && !fire, in_valid_q && $stable(in_q), "waiting item lost")
  `SLTS_ASSERT_NEXT(a_line_reset, fire && in_q.line_end, state_q.line_position == '0 && !state_q.depth_count[DEPTH_BITS-1], "line end left state")
  `SLTS_ASSERT(a_pos_bound, state_q.line_position <= LINE_W'(MAX_LINE), "line position overran")

endmodule

[test/tb_top.sv]
// Self-checking testbench for the source line token scanner: directed rows, then random lines.
module tb_top;
  import slts_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ITEMS_PER_PHASE = 110;

  typedef struct {
    in_t  item;
    bit   typed;
    res_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;

  int send_idle = 0;
  int recv_idle = 0;
  int mism_count = 0;
  int real_items = 0;

  res_t expected_q[$];
  res_t step_res[$];
  in_t  stim_q[$];
  row_t dir_rows[$];

  // Scanner state as predicted from the accepted transactions.
  logic [2:0]  scan_mode = MODE_START;
  logic [12:0] tok_begin = '0;
  logic [7:0]  quote_ch = '0;
  logic [7:0]  prev_ch = '0;
  bit          held = 1'b0;
  logic [12:0] line_pos = '0;
  int          depth = 0;

  source_line_token_scanner_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void put_res(kind_e k, logic [12:0] begin_pos, logic [12:0] len, bit blk);
    res_t r;
    if (step_res.size() >= MAX_RES) return;
    r.kind = k;
    r.span_start = begin_pos[POS_W-1:0];
    r.span_length = len;
    r.brace_depth = depth[DEPTH_BITS-1:0];
    r.in_block_comment = blk;
    r.last = 1'b0;
    step_res.push_back(r);
  endfunction

  function automatic void step_depth(bit up);
    int hi;
    hi = (1 << (DEPTH_BITS - 1)) - 1;
    if (up) begin
      if (depth < hi) depth++;
    end else begin
      if (depth > -hi - 1) depth--;
    end
  endfunction

  function automatic void begin_token(logic [7:0] c, logic [12:0] pos);
    tok_begin = pos;
    if (is_blank(c)) begin
      return;
    end else if (is_num(c)) begin
      scan_mode = MODE_NUMBER;
    end else if (is_alpha(c) || c == "_") begin
      scan_mode = MODE_IDENT;
    end else if (c == "'" || c == "\"") begin
      scan_mode = MODE_STRING;
      quote_ch = c;
    end else if (c == "/") begin
      held = 1'b1;
    end else if (c == "{") begin
      step_depth(1'b1);
      put_res(KIND_OPEN, pos, 13'd1, 1'b0);
    end else if (c == "}") begin
      step_depth(1'b0);
      put_res(KIND_CLOSE, pos, 13'd1, 1'b0);
    end else if (c != "(" && c != ")" && c != "[" && c != "]") begin
      put_res(KIND_OPERATOR, pos, 13'd1, 1'b0);
    end
  endfunction

  function automatic void feed_byte(logic [7:0] c, logic [12:0] pos);
    case (scan_mode)
      MODE_NUMBER: begin
        if (!is_num(c)) begin
          put_res(KIND_NUMBER, tok_begin, pos - tok_begin, 1'b0);
          scan_mode = MODE_START;
          begin_token(c, pos);
        end
      end
      MODE_IDENT: begin
        if (!(is_num(c) || is_alpha(c) || c == "_")) begin
          put_res(KIND_IDENT, tok_begin, pos - tok_begin, 1'b0);
          scan_mode = MODE_START;
          begin_token(c, pos);
        end
      end
      MODE_STRING: begin
        if (c == quote_ch && prev_ch != "\\") begin
          put_res(KIND_STRING, tok_begin, pos + 13'd1 - tok_begin, 1'b0);
          scan_mode = MODE_START;
        end
      end
      MODE_BLOCK: begin
        if (c == "*") held = 1'b1;
      end
      MODE_LINECMT: begin
      end
      default: begin
        scan_mode = MODE_START;
        begin_token(c, pos);
      end
    endcase
  endfunction

  // The held byte is a slash outside a token or a star inside a block comment.
  function automatic void resolve_held(logic [7:0] c, logic [12:0] pos);
    held = 1'b0;
    if (scan_mode == MODE_BLOCK) begin
      if (c == "/") begin
        put_res(KIND_COMMENT, tok_begin, pos + 13'd1 - tok_begin, 1'b0);
        scan_mode = MODE_START;
      end else begin
        feed_byte(c, pos);
      end
    end else if (c == "*") begin
      scan_mode = MODE_BLOCK;
    end else if (c == "/") begin
      scan_mode = MODE_LINECMT;
    end else begin
      put_res(KIND_OPERATOR, tok_begin, 13'd1, 1'b0);
      feed_byte(c, pos);
    end
  endfunction

  function automatic void close_line();
    logic [12:0] len;
    bit blk;
    len = line_pos;
    if (held) begin
      held = 1'b0;
      if (scan_mode != MODE_BLOCK) put_res(KIND_OPERATOR, tok_begin, 13'd1, 1'b0);
    end
    case (scan_mode)
      MODE_NUMBER: put_res(KIND_NUMBER, tok_begin, len - tok_begin, 1'b0);
      MODE_IDENT: put_res(KIND_IDENT, tok_begin, len - tok_begin, 1'b0);
      MODE_LINECMT, MODE_BLOCK: begin
        if (len > tok_begin) put_res(KIND_COMMENT, tok_begin, len - tok_begin, 1'b0);
      end
      default: begin
      end
    endcase
    blk = (scan_mode == MODE_BLOCK);
    put_res(KIND_STATUS, '0, len, blk);
    scan_mode = blk ? MODE_BLOCK : MODE_START;
    // A line that leaves the depth negative restarts the next line from scratch.
    if (depth < 0) begin
      depth = 0;
      scan_mode = MODE_START;
    end
    tok_begin = '0;
    quote_ch = '0;
    prev_ch = '0;
    line_pos = '0;
  endfunction

  function automatic void scan_predict(in_t it);
    logic [12:0] pos;
    res_t r;
    step_res.delete();
    if (it.has_char && line_pos < MAX_LINE) begin
      pos = line_pos;
      if (held) resolve_held(it.ch, pos);
      else feed_byte(it.ch, pos);
      prev_ch = it.ch;
      line_pos = pos + 13'd1;
    end
    if (it.line_end) close_line();
    if (step_res.size() != 0) begin
      r = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  function automatic void log_mismatch(string what, res_t want, res_t got);
    mism_count++;
    if (mism_count <= 10) begin
      $display("%s: expected kind=%0d start=%0d len=%0d depth=%0d blk=%0b last=%0b",
               what, want.kind, want.span_start, want.span_length, want.brace_depth,
               want.in_block_comment, want.last);
      $display("  got kind=%0d start=%0d len=%0d depth=%0d blk=%0b last=%0b",
               got.kind, got.span_start, got.span_length, got.brace_depth,
               got.in_block_comment, got.last);
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        log_mismatch("unexpected result", '0, out_data);
      end else begin
        want = expected_q.pop_front();
        if (want.kind !== out_data.kind || want.span_start !== out_data.span_start ||
            want.span_length !== out_data.span_length ||
            want.brace_depth !== out_data.brace_depth ||
            want.in_block_comment !== out_data.in_block_comment ||
            want.last !== out_data.last) begin
          log_mismatch("mismatch", want, out_data);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_item(input in_t it, input bit typed, input res_t want);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    scan_predict(it);
    if (typed) expected_q.push_back(want);
    else foreach (step_res[k]) expected_q.push_back(step_res[k]);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void add_row(logic [7:0] c, bit has, bit fin);
    row_t r;
    r.item = '{ch: c, has_char: has, line_end: fin};
    r.typed = 1'b0;
    r.want = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_typed(logic [7:0] c, bit has, bit fin, kind_e k, int st,
                                    int len, int dep, bit blk);
    row_t r;
    r.item = '{ch: c, has_char: has, line_end: fin};
    r.typed = 1'b1;
    r.want.kind = k;
    r.want.span_start = POS_W'(st);
    r.want.span_length = LINE_W'(len);
    r.want.brace_depth = DEPTH_BITS'(dep);
    r.want.in_block_comment = blk;
    r.want.last = 1'b1;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_byte(logic [7:0] c);
    stim_q.push_back('{ch: c, has_char: 1'b1, line_end: 1'b0});
    real_items++;
  endfunction

  function automatic void pick_from(string s);
    add_byte(s[$urandom_range(s.len() - 1)]);
  endfunction

  function automatic logic [7:0] rand_alpha();
    return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25)) : 8'(8'h41 + $urandom_range(25));
  endfunction

  // Ends a line either on its last byte or with a byte-less transaction.
  function automatic void end_line(int first_idx);
    in_t t;
    if (stim_q.size() > first_idx && $urandom_range(1)) begin
      t = stim_q.pop_back();
      t.line_end = 1'b1;
      stim_q.push_back(t);
    end else begin
      t = '{ch: 8'($urandom_range(255)), has_char: 1'b0, line_end: 1'b1};
      stim_q.push_back(t);
      real_items++;
    end
  endfunction

  function automatic void gen_token();
    int n;
    logic [7:0] q;
    case ($urandom_range(13))
      0, 1: begin
        add_byte($urandom_range(4) == 0 ? 8'("_") : rand_alpha());
        n = $urandom_range(4);
        repeat (n) begin
          case ($urandom_range(2))
            0: add_byte(rand_alpha());
            1: add_byte(8'("0" + $urandom_range(9)));
            default: add_byte("_");
          endcase
        end
      end
      2: begin
        repeat ($urandom_range(1, 4)) add_byte(8'("0" + $urandom_range(9)));
      end
      3, 4: begin
        q = $urandom_range(1) ? 8'("'") : 8'("\"");
        add_byte(q);
        repeat ($urandom_range(4)) pick_from("ab \\'\"x");
        if ($urandom_range(4) != 0) add_byte(q);
      end
      5: begin
        add_byte("/");
        add_byte("*");
        repeat ($urandom_range(4)) pick_from("a*/ *x");
        if ($urandom_range(2) != 0) begin
          add_byte("*");
          add_byte("/");
        end
      end
      6: begin
        add_byte("/");
        add_byte("/");
        repeat ($urandom_range(3)) pick_from("k/*{ 7");
      end
      7: pick_from("+-=<>;,.!&|^~%?:#@$*/");
      8, 9: pick_from("{}{}()[]");
      10: begin
        if ($urandom_range(1)) add_byte(" ");
        else add_byte(8'($urandom_range(13, 9)));
      end
      11: add_byte(8'($urandom_range(255)));
      12: stim_q.push_back('{ch: 8'($urandom_range(255)), has_char: 1'b0, line_end: 1'b0});
      default: add_byte("/");
    endcase
  endfunction

  task automatic run_random(int n);
    int first_idx;
    real_items = 0;
    while (real_items < n) begin
      first_idx = stim_q.size();
      repeat ($urandom_range(6)) begin
        gen_token();
        if ($urandom_range(2) == 0) add_byte(" ");
      end
      end_line(first_idx);
    end
    while (stim_q.size() != 0) push_item(stim_q.pop_front(), 1'b0, '0);
  endtask

  initial begin
    // Line of a brace pair, closed by a byte-less transaction.
    add_typed("{", 1'b1, 1'b0, KIND_OPEN, 0, 1, 1, 1'b0);
    add_typed("}", 1'b1, 1'b0, KIND_CLOSE, 1, 1, 0, 1'b0);
    add_typed(8'hA5, 1'b0, 1'b1, KIND_STATUS, 0, 2, 0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0);
    // Operator byte, number, identifier, escaped quote inside a string, then a line comment.
    add_typed(8'hFF, 1'b1, 1'b0, KIND_OPERATOR, 0, 1, 0, 1'b0);
    add_row("9", 1'b1, 1'b0);
    add_row("a", 1'b1, 1'b0);
    add_row("\"", 1'b1, 1'b0);
    add_row("\\", 1'b1, 1'b0);
    add_row("\"", 1'b1, 1'b0);
    add_row("\"", 1'b1, 1'b0);
    add_row("/", 1'b1, 1'b0);
    add_row("/", 1'b1, 1'b0);
    add_row("(", 1'b1, 1'b1);
    // Block comment that runs past the line end, then an empty line inside it.
    add_row("/", 1'b1, 1'b0);
    add_row("*", 1'b1, 1'b1);
    add_typed(8'h00, 1'b0, 1'b1, KIND_STATUS, 0, 0, 0, 1'b1);
    // Close the carried comment, then leave a string open at the line end.
    add_row("*", 1'b1, 1'b0);
    add_row("/", 1'b1, 1'b0);
    add_row("'", 1'b1, 1'b0);
    add_row("a", 1'b1, 1'b1);
    // Depth goes negative on this line.
    add_row("}", 1'b1, 1'b1);
    // Slash still held when the line ends.
    add_row(8'h09, 1'b1, 1'b0);
    add_row("/", 1'b1, 1'b0);
    add_row(8'h5A, 1'b0, 1'b1);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle = 8;
    recv_idle = 55;
    foreach (dir_rows[k]) push_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    send_idle = 55;
    recv_idle = 8;
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    run_random(ITEMS_PER_PHASE);
    wait_idle();

    if (mism_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
